// ----- design/wet_pkg.sv -----
`default_nettype none

package wet_pkg;

   localparam int COORD_W    = 32;
   localparam int EDGE_W     = COORD_W + 1;
   localparam int PROD_W     = 2 * EDGE_W;
   localparam int DOT_W      = PROD_W + 2;
   localparam int THR_W      = 31;
   localparam int THR_FRAC   = 30;
   localparam int T2_W       = 2 * THR_W;
   localparam int RGB_W      = 24;
   localparam int CSR_W      = THR_W;
   localparam int CSR_IDX_W  = 2;
   localparam int NUM_AXES   = 3;
   localparam int NUM_EDGES  = 3;

   localparam int DIG_W      = 32;
   localparam int MUL_DIGITS = 7;
   localparam int MUL_W      = DIG_W * MUL_DIGITS;
   localparam int MUL_PW     = 2 * MUL_W;
   localparam int MUL_PARTS  = MUL_DIGITS * MUL_DIGITS;
   localparam int MUL_TREE   = $clog2(MUL_PARTS);
   localparam int MUL_LAT    = MUL_TREE + 3;
   localparam int LAST_STAGE = 3 * MUL_LAT + 6;

   localparam logic [THR_W-1:0] THR_RESET  = 31'd1073741745;
   localparam logic [THR_W-1:0] THR_ONE    = 31'h4000_0000;
   localparam logic [RGB_W-1:0] LINE_RESET = 24'h00_0000;
   localparam logic [RGB_W-1:0] FILL_RESET = 24'hFF_FFFF;

   localparam int EDGE_FROM [NUM_EDGES] = '{0, 1, 2};
   localparam int EDGE_TO   [NUM_EDGES] = '{2, 0, 1};

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [EDGE_W-1:0]  edge_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [DOT_W-1:0]   dot_type;
   typedef logic [MUL_W-1:0]          mul_type;
   typedef logic [MUL_PW-1:0]         mpw_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COS_THRESHOLD = 2'd0,
      CSR_LINE_RGB      = 2'd1,
      CSR_FILL_RGB      = 2'd2
   } csr_index_type;

   function automatic mul_type ext_dot(dot_type x);
      return MUL_W'(x);
   endfunction

endpackage

`default_nettype wire

// ----- design/wet_req_if.sv -----
`default_nettype none

interface wet_req_if;
   logic                valid;
   logic                ready;
   wet_pkg::coord_type  hit_x;
   wet_pkg::coord_type  hit_y;
   wet_pkg::coord_type  hit_z;
   wet_pkg::coord_type  vert0_x;
   wet_pkg::coord_type  vert0_y;
   wet_pkg::coord_type  vert0_z;
   wet_pkg::coord_type  vert1_x;
   wet_pkg::coord_type  vert1_y;
   wet_pkg::coord_type  vert1_z;
   wet_pkg::coord_type  vert2_x;
   wet_pkg::coord_type  vert2_y;
   wet_pkg::coord_type  vert2_z;

   modport source (output valid, hit_x, hit_y, hit_z, vert0_x, vert0_y, vert0_z,
                   vert1_x, vert1_y, vert1_z, vert2_x, vert2_y, vert2_z, input ready);
   modport sink   (input valid, hit_x, hit_y, hit_z, vert0_x, vert0_y, vert0_z,
                   vert1_x, vert1_y, vert1_z, vert2_x, vert2_y, vert2_z, output ready);
endinterface

`default_nettype wire

// ----- design/wet_rsp_if.sv -----
`default_nettype none

interface wet_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        on_edge;
   logic [wet_pkg::RGB_W-1:0]   shade_rgb;

   modport source (output valid, on_edge, shade_rgb, input ready);
   modport sink   (input valid, on_edge, shade_rgb, output ready);
endinterface

`default_nettype wire

// ----- design/wireframe_edge_test_unit.sv -----
`default_nettype none

// Channel   Dir  Transfer when          Carries
// req_bus   in   valid && ready         hit point and three vertices, Q16.16
// rsp_bus   out  valid && ready         on_edge flag and chosen colour
// csr_*     in   csr_we                 threshold, line and fill colours
//
// One item per cycle while the skid entry is empty; the result path runs through
// three 9-stage multipliers in series inside each edge lane.
// Reset clears the valid chain, the skid entry and the registers to defaults.
// A skid entry holds one result when rsp stalls; req_ready drops while it is
// full and the whole pipeline holds.

module wireframe_edge_test_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   wet_req_if.sink                             req_bus,
   wet_rsp_if.source                           rsp_bus,
   input  wire logic                           csr_we,
   input  wire logic [wet_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [wet_pkg::CSR_W-1:0]      csr_wdata
);
   localparam int NA   = wet_pkg::NUM_AXES;
   localparam int NE   = wet_pkg::NUM_EDGES;
   localparam int L    = wet_pkg::MUL_LAT;
   localparam int LAST = wet_pkg::LAST_STAGE;

   logic [wet_pkg::THR_W-1:0] thr_ff;
   logic [wet_pkg::RGB_W-1:0] line_ff;
   logic [wet_pkg::RGB_W-1:0] fill_ff;
   logic [wet_pkg::T2_W-1:0]  t2_ff;

   logic                      en;
   logic [LAST:0]             v_ff;
   wet_pkg::coord_type        hit_ff  [NA];
   wet_pkg::coord_type        vert_ff [NE][NA];

   wet_pkg::coord_type        c1_ff  [NA];
   wet_pkg::prod_type         csq_ff [NA];
   wet_pkg::dot_type          cc_ff;
   wet_pkg::dot_type          ccd_ff [L+1];
   logic                      nz_ff;
   logic                      nzd_ff [3*L+1];
   wet_pkg::mpw_type          tc;

   logic [NE-1:0]             pass_w;
   logic                      hit_w;

   logic                      out_on_ff;
   logic [wet_pkg::RGB_W-1:0] out_rgb_ff;
   logic                      skid_v_ff;
   logic                      skid_on_ff;
   logic [wet_pkg::RGB_W-1:0] skid_rgb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= wet_pkg::THR_RESET;
         line_ff <= wet_pkg::LINE_RESET;
         fill_ff <= wet_pkg::FILL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            wet_pkg::CSR_COS_THRESHOLD: thr_ff  <= csr_wdata;
            wet_pkg::CSR_LINE_RGB:      line_ff <= csr_wdata[wet_pkg::RGB_W-1:0];
            wet_pkg::CSR_FILL_RGB:      fill_ff <= csr_wdata[wet_pkg::RGB_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      t2_ff <= thr_ff * thr_ff;
   end

   assign en            = !skid_v_ff;
   assign req_bus.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[LAST-1:0], req_bus.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff[0]     <= req_bus.hit_x;
         hit_ff[1]     <= req_bus.hit_y;
         hit_ff[2]     <= req_bus.hit_z;
         vert_ff[0][0] <= req_bus.vert0_x;
         vert_ff[0][1] <= req_bus.vert0_y;
         vert_ff[0][2] <= req_bus.vert0_z;
         vert_ff[1][0] <= req_bus.vert1_x;
         vert_ff[1][1] <= req_bus.vert1_y;
         vert_ff[1][2] <= req_bus.vert1_z;
         vert_ff[2][0] <= req_bus.vert2_x;
         vert_ff[2][1] <= req_bus.vert2_y;
         vert_ff[2][2] <= req_bus.vert2_z;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NA; k++) begin
            c1_ff[k]  <= hit_ff[k];
            csq_ff[k] <= c1_ff[k] * c1_ff[k];
         end
         cc_ff     <= csq_ff[0] + csq_ff[1] + csq_ff[2];
         ccd_ff[0] <= cc_ff;
         for (int i = 1; i < L + 1; i++) begin
            ccd_ff[i] <= ccd_ff[i-1];
         end
         nz_ff     <= cc_ff != '0;
         nzd_ff[0] <= nz_ff;
         for (int i = 1; i < 3 * L + 1; i++) begin
            nzd_ff[i] <= nzd_ff[i-1];
         end
      end
   end

   wet_mul u_tc (
      .clock,
      .en,
      .a (wet_pkg::ext_dot(ccd_ff[L])),
      .b (wet_pkg::MUL_W'(t2_ff)),
      .p (tc)
   );

   for (genvar g = 0; g < NE; g++) begin : g_lane
      wet_lane u_lane (
         .clock,
         .en,
         .hit  (hit_ff),
         .va   (vert_ff[wet_pkg::EDGE_FROM[g]]),
         .vb   (vert_ff[wet_pkg::EDGE_TO[g]]),
         .tc   (tc[wet_pkg::MUL_W-1:0]),
         .pass (pass_w[g])
      );
   end

   assign hit_w = nzd_ff[3*L] && (|pass_w);

   always_ff @(posedge clock) begin
      if (en) begin
         out_on_ff  <= hit_w;
         out_rgb_ff <= hit_w ? line_ff : fill_ff;
      end
   end

   // hold the stalled result in the skid entry while the pipeline advances once
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (rsp_bus.ready) begin
            skid_v_ff <= 1'b0;
         end
      end else if (v_ff[LAST] && !rsp_bus.ready) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_v_ff) begin
         skid_on_ff  <= out_on_ff;
         skid_rgb_ff <= out_rgb_ff;
      end
   end

   assign rsp_bus.valid     = skid_v_ff || v_ff[LAST];
   assign rsp_bus.on_edge   = skid_v_ff ? skid_on_ff : out_on_ff;
   assign rsp_bus.shade_rgb = skid_v_ff ? skid_rgb_ff : out_rgb_ff;

   a_thr_above_one : assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (thr_ff > wet_pkg::THR_ONE)) |-> !rsp_bus.on_edge)
      else $error("edge passed with threshold above one");

   a_shade_select : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |->
         (rsp_bus.shade_rgb == (rsp_bus.on_edge ? line_ff : fill_ff)))
      else $error("shade does not match on_edge");

   a_skid_fill : assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(v_ff[LAST] && !rsp_bus.ready))
      else $error("skid filled without a stalled result");

endmodule

`default_nettype wire

// ----- design/wet_mul.sv -----
`default_nettype none

module wet_mul (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire wet_pkg::mul_type  a,
   input  wire wet_pkg::mul_type  b,
   output wet_pkg::mpw_type       p
);
   localparam int ND = wet_pkg::MUL_DIGITS;
   localparam int NP = wet_pkg::MUL_PARTS;
   localparam int NT = wet_pkg::MUL_TREE;
   localparam int DW = wet_pkg::DIG_W;

   wet_pkg::mul_type mag_a_ff;
   wet_pkg::mul_type mag_b_ff;
   logic             neg_ff [NT+2];
   wet_pkg::mpw_type lvl_ff [NT+1][NP];
   wet_pkg::mpw_type p_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         mag_a_ff  <= a[wet_pkg::MUL_W-1] ? (~a + 1'b1) : a;
         mag_b_ff  <= b[wet_pkg::MUL_W-1] ? (~b + 1'b1) : b;
         neg_ff[0] <= a[wet_pkg::MUL_W-1] ^ b[wet_pkg::MUL_W-1];
         for (int i = 1; i < NT + 2; i++) begin
            neg_ff[i] <= neg_ff[i-1];
         end
      end
   end

   for (genvar i = 0; i < ND; i++) begin : g_row
      for (genvar j = 0; j < ND; j++) begin : g_col
         logic [2*DW-1:0] pp;
         assign pp = mag_a_ff[i*DW +: DW] * mag_b_ff[j*DW +: DW];
         always_ff @(posedge clock) begin
            if (en) begin
               lvl_ff[0][i*ND+j] <= wet_pkg::MUL_PW'(pp) << (DW * (i + j));
            end
         end
      end
   end

   for (genvar l = 1; l <= NT; l++) begin : g_lvl
      localparam int NCUR = (NP + (1 << l) - 1) >> l;
      localparam int NPRV = (NP + (1 << (l - 1)) - 1) >> (l - 1);
      for (genvar k = 0; k < NP; k++) begin : g_node
         wet_pkg::mpw_type sum;
         if (k < NCUR) begin : g_used
            if (2 * k + 1 < NPRV) begin : g_pair
               assign sum = lvl_ff[l-1][2*k] + lvl_ff[l-1][2*k+1];
            end else begin : g_single
               assign sum = lvl_ff[l-1][2*k];
            end
         end else begin : g_unused
            assign sum = '0;
         end
         always_ff @(posedge clock) begin
            if (en) begin
               lvl_ff[l][k] <= sum;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= neg_ff[NT+1] ? (~lvl_ff[NT][0] + 1'b1) : lvl_ff[NT][0];
      end
   end

   assign p = p_ff;

endmodule

`default_nettype wire

// ----- design/wet_lane.sv -----
`default_nettype none

module wet_lane (
   input  wire logic                clock,
   input  wire logic                en,
   input  wire wet_pkg::coord_type  hit [wet_pkg::NUM_AXES],
   input  wire wet_pkg::coord_type  va  [wet_pkg::NUM_AXES],
   input  wire wet_pkg::coord_type  vb  [wet_pkg::NUM_AXES],
   input  wire wet_pkg::mul_type    tc,
   output logic                     pass
);
   localparam int NA = wet_pkg::NUM_AXES;
   localparam int L  = wet_pkg::MUL_LAT;

   wet_pkg::edge_type  e_ff  [NA];
   wet_pkg::edge_type  h_ff  [NA];
   wet_pkg::coord_type a1_ff [NA];
   wet_pkg::coord_type c1_ff [NA];

   wet_pkg::prod_type  ee_ff [NA];
   wet_pkg::prod_type  ae_ff [NA];
   wet_pkg::prod_type  ce_ff [NA];
   wet_pkg::prod_type  he_ff [NA];
   wet_pkg::prod_type  aa_ff [NA];
   wet_pkg::prod_type  ac_ff [NA];

   wet_pkg::dot_type   d_ff, u_ff, w_ff, n_ff, a2_ff, ac2_ff;
   wet_pkg::dot_type   dd_ff [L];

   wet_pkg::mpw_type   m_daa, m_ww, m_uu, m_dac, m_nw, m_ss, m_dp, m_rr;
   wet_pkg::mpw_type   p_sum, s_sum;
   wet_pkg::mul_type   p_ff, s_ff;
   wet_pkg::dot_type   d4_ff;

   logic               ok_ff;
   logic               okd_ff [2*L-1];
   wet_pkg::mpw_type   s2d_ff [L];
   wet_pkg::mpw_type   lhs;
   logic               pass_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NA; k++) begin
            e_ff[k]  <= wet_pkg::edge_type'(vb[k]) - wet_pkg::edge_type'(va[k]);
            h_ff[k]  <= wet_pkg::edge_type'(hit[k]) - wet_pkg::edge_type'(va[k]);
            a1_ff[k] <= va[k];
            c1_ff[k] <= hit[k];
         end
         for (int k = 0; k < NA; k++) begin
            ee_ff[k] <= e_ff[k] * e_ff[k];
            ae_ff[k] <= a1_ff[k] * e_ff[k];
            ce_ff[k] <= c1_ff[k] * e_ff[k];
            he_ff[k] <= h_ff[k] * e_ff[k];
            aa_ff[k] <= a1_ff[k] * a1_ff[k];
            ac_ff[k] <= a1_ff[k] * c1_ff[k];
         end
         d_ff   <= ee_ff[0] + ee_ff[1] + ee_ff[2];
         u_ff   <= ae_ff[0] + ae_ff[1] + ae_ff[2];
         w_ff   <= ce_ff[0] + ce_ff[1] + ce_ff[2];
         n_ff   <= he_ff[0] + he_ff[1] + he_ff[2];
         a2_ff  <= aa_ff[0] + aa_ff[1] + aa_ff[2];
         ac2_ff <= ac_ff[0] + ac_ff[1] + ac_ff[2];
         dd_ff[0] <= d_ff;
         for (int i = 1; i < L; i++) begin
            dd_ff[i] <= dd_ff[i-1];
         end
      end
   end

   // |Q|^2 = D * (D*|a|^2 + w^2 - u^2), Q.c = D*(a.c) + N*w
   wet_mul u_daa (.clock, .en, .a(wet_pkg::ext_dot(d_ff)), .b(wet_pkg::ext_dot(a2_ff)),
                  .p(m_daa));
   wet_mul u_ww  (.clock, .en, .a(wet_pkg::ext_dot(w_ff)), .b(wet_pkg::ext_dot(w_ff)),
                  .p(m_ww));
   wet_mul u_uu  (.clock, .en, .a(wet_pkg::ext_dot(u_ff)), .b(wet_pkg::ext_dot(u_ff)),
                  .p(m_uu));
   wet_mul u_dac (.clock, .en, .a(wet_pkg::ext_dot(d_ff)), .b(wet_pkg::ext_dot(ac2_ff)),
                  .p(m_dac));
   wet_mul u_nw  (.clock, .en, .a(wet_pkg::ext_dot(n_ff)), .b(wet_pkg::ext_dot(w_ff)),
                  .p(m_nw));

   assign p_sum = m_daa + m_ww - m_uu;
   assign s_sum = m_dac + m_nw;

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff  <= p_sum[wet_pkg::MUL_W-1:0];
         s_ff  <= s_sum[wet_pkg::MUL_W-1:0];
         d4_ff <= dd_ff[L-1];
         ok_ff <= (d4_ff != '0) && (p_ff != '0) && !s_ff[wet_pkg::MUL_W-1];
         okd_ff[0] <= ok_ff;
         for (int i = 1; i < 2 * L - 1; i++) begin
            okd_ff[i] <= okd_ff[i-1];
         end
      end
   end

   wet_mul u_ss (.clock, .en, .a(s_ff), .b(s_ff), .p(m_ss));
   wet_mul u_dp (.clock, .en, .a(wet_pkg::ext_dot(d4_ff)), .b(p_ff), .p(m_dp));
   wet_mul u_rr (.clock, .en, .a(m_dp[wet_pkg::MUL_W-1:0]), .b(tc), .p(m_rr));

   assign lhs = s2d_ff[L-1] << (2 * wet_pkg::THR_FRAC);

   always_ff @(posedge clock) begin
      if (en) begin
         s2d_ff[0] <= m_ss;
         for (int i = 1; i < L; i++) begin
            s2d_ff[i] <= s2d_ff[i-1];
         end
         pass_ff <= okd_ff[2*L-2] && (lhs >= m_rr);
      end
   end

   assign pass = pass_ff;

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

   localparam int LIMIT_CYCLES = 2_000_000;
   localparam int DRAIN_CYCLES = 40;
   localparam int NUM_FIELDS   = 12;
   localparam logic [wet_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef logic signed [447:0] wide_type;
   typedef wet_pkg::coord_type hit_item_type [NUM_FIELDS];
   typedef struct packed {
      logic                      on_edge;
      logic [wet_pkg::RGB_W-1:0] shade_rgb;
   } shade_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [wet_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [wet_pkg::CSR_W-1:0] csr_wdata = '0;

   wet_req_if req_bus ();
   wet_rsp_if rsp_bus ();

   wireframe_edge_test_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus.sink),
      .rsp_bus   (rsp_bus.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic [wet_pkg::THR_W-1:0] cos_limit = wet_pkg::THR_RESET;
   logic [wet_pkg::RGB_W-1:0] line_color = wet_pkg::LINE_RESET;
   logic [wet_pkg::RGB_W-1:0] fill_color = wet_pkg::FILL_RESET;
   shade_type expected_shades [$];
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int mismatches = 0;
   int cycles = 0;
   int items_sent = 0;
   int edge_hits = 0;

   always #1 clock = ~clock;

   initial begin
      req_bus.valid = 1'b0;
      rsp_bus.ready = 1'b0;
      {req_bus.hit_x, req_bus.hit_y, req_bus.hit_z} = '0;
      {req_bus.vert0_x, req_bus.vert0_y, req_bus.vert0_z} = '0;
      {req_bus.vert1_x, req_bus.vert1_y, req_bus.vert1_z} = '0;
      {req_bus.vert2_x, req_bus.vert2_y, req_bus.vert2_z} = '0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);

   function automatic bit edge_passes(input wide_type c [3], input wide_type a [3],
                                      input wide_type b [3], input wide_type cc,
                                      input logic [wet_pkg::THR_W-1:0] thr);
      wide_type e [3];
      wide_type q [3];
      wide_type d, n, qq, s, lhs, rhs, t;
      int k;
      d = 0;
      n = 0;
      for (k = 0; k < 3; k++) begin
         e[k] = b[k] - a[k];
         d += e[k] * e[k];
         n += (c[k] - a[k]) * e[k];
      end
      if (d == 0) return 1'b0;
      qq = 0;
      s = 0;
      for (k = 0; k < 3; k++) begin
         q[k] = a[k] * d + n * e[k];
         qq += q[k] * q[k];
         s += q[k] * c[k];
      end
      if (qq == 0 || s < 0) return 1'b0;
      if (thr == 0) return 1'b1;
      lhs = (s * s) <<< 60;
      t = wide_type'(thr);
      rhs = t * t * qq * cc;
      return lhs >= rhs;
   endfunction

   function automatic shade_type predict_shade(input hit_item_type f);
      wide_type c [3];
      wide_type v [3][3];
      wide_type cc;
      shade_type r;
      bit hit;
      int k, i;
      cc = 0;
      for (k = 0; k < 3; k++) begin
         c[k] = wide_type'(f[k]);
         cc += c[k] * c[k];
         for (i = 0; i < 3; i++) v[i][k] = wide_type'(f[3 + 3 * i + k]);
      end
      hit = 1'b0;
      if (cc != 0)
         for (i = 0; i < wet_pkg::NUM_EDGES; i++)
            hit |= edge_passes(c, v[wet_pkg::EDGE_FROM[i]], v[wet_pkg::EDGE_TO[i]], cc,
                               cos_limit);
      r.on_edge = hit;
      r.shade_rgb = hit ? line_color : fill_color;
      return r;
   endfunction

   always @(posedge clock) begin
      shade_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_shades.size() == 0) begin
            $error("unexpected result transfer");
            mismatches++;
         end else begin
            want = expected_shades.pop_front();
            if (rsp_bus.on_edge !== want.on_edge) begin
               $error("on_edge expected %0d actual %0d", want.on_edge, rsp_bus.on_edge);
               mismatches++;
            end
            if (rsp_bus.shade_rgb !== want.shade_rgb) begin
               $error("shade_rgb expected %h actual %h", want.shade_rgb, rsp_bus.shade_rgb);
               mismatches++;
            end
         end
      end
   end

   task automatic send_item(input hit_item_type f);
      shade_type want;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      {req_bus.hit_x, req_bus.hit_y, req_bus.hit_z} <= {f[0], f[1], f[2]};
      {req_bus.vert0_x, req_bus.vert0_y, req_bus.vert0_z} <= {f[3], f[4], f[5]};
      {req_bus.vert1_x, req_bus.vert1_y, req_bus.vert1_z} <= {f[6], f[7], f[8]};
      {req_bus.vert2_x, req_bus.vert2_y, req_bus.vert2_z} <= {f[9], f[10], f[11]};
      req_bus.valid <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      want = predict_shade(f);
      expected_shades.push_back(want);
      items_sent++;
      edge_hits += want.on_edge;
   endtask

   task automatic drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_shades.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [wet_pkg::CSR_IDX_W-1:0] idx,
                            input logic [wet_pkg::CSR_W-1:0] value);
      drain();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         wet_pkg::CSR_COS_THRESHOLD: cos_limit = value;
         wet_pkg::CSR_LINE_RGB:      line_color = value[wet_pkg::RGB_W-1:0];
         wet_pkg::CSR_FILL_RGB:      fill_color = value[wet_pkg::RGB_W-1:0];
         default: ;
      endcase
   endtask

   function automatic wet_pkg::coord_type rand_coord();
      case ($urandom_range(3))
         0: return wet_pkg::coord_type'($urandom);
         1: return wet_pkg::coord_type'($signed($urandom_range(2000)) - 1000);
         2: return $urandom_range(1) ? wet_pkg::coord_type'(32'h7FFF_FFFF)
                                     : wet_pkg::coord_type'(32'h8000_0000);
         default: return wet_pkg::coord_type'($signed($urandom_range(1 << 22)) - (1 << 21));
      endcase
   endfunction

   // build a hit lying on one edge line, with optional small jitter
   function automatic hit_item_type on_edge_item();
      hit_item_type f;
      wet_pkg::coord_type p [3];
      wet_pkg::coord_type e [3];
      int j, k, t;
      j = $urandom_range(wet_pkg::NUM_EDGES - 1);
      t = $signed($urandom_range(16)) - 4;
      for (k = 0; k < 3; k++) begin
         p[k] = wet_pkg::coord_type'($signed($urandom_range(1 << 24)) - (1 << 23));
         e[k] = wet_pkg::coord_type'(8 * ($signed($urandom_range(1 << 20)) - (1 << 19)));
         f[3 + 3 * wet_pkg::EDGE_FROM[j] + k] = p[k];
         f[3 + 3 * wet_pkg::EDGE_TO[j] + k] = p[k] + e[k];
         f[3 + 3 * (3 - wet_pkg::EDGE_FROM[j] - wet_pkg::EDGE_TO[j]) + k] = rand_coord();
         f[k] = p[k] + (e[k] / 8) * t;
         if ($urandom_range(2) == 0)
            f[k] += wet_pkg::coord_type'($signed($urandom_range(64)) - 32);
      end
      return f;
   endfunction

   function automatic hit_item_type random_item();
      hit_item_type f;
      int k;
      case ($urandom_range(19))
         0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: f = on_edge_item();
         12: begin
            f = on_edge_item();
            for (k = 0; k < 3; k++) f[6 + k] = f[3 + k];
         end
         default:
            for (k = 0; k < NUM_FIELDS; k++) f[k] = rand_coord();
      endcase
      return f;
   endfunction

   function automatic hit_item_type make_item(input wet_pkg::coord_type c0, c1, c2,
                                              a0, a1, a2, b0, b1, b2, d0, d1, d2);
      hit_item_type f;
      f = '{c0, c1, c2, a0, a1, a2, b0, b1, b2, d0, d1, d2};
      return f;
   endfunction

   task automatic test_directed();
      hit_item_type f;
      int k;
      for (k = 0; k < NUM_FIELDS; k++) f[k] = 32'h7FFF_FFFF;
      send_item(f);
      for (k = 0; k < NUM_FIELDS; k++) f[k] = 32'h8000_0000;
      send_item(f);
      for (k = 0; k < NUM_FIELDS; k++) f[k] = k[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      send_item(f);
      // hit at camera origin
      send_item(make_item(0, 0, 0, 1, 2, 3, 4, 5, 6, 7, 8, 10));
      // collapsed triangle
      send_item(make_item(5, 5, 5, 9, 9, 9, 9, 9, 9, 9, 9, 9));
      // hit on each edge line
      send_item(make_item(20, 20, 100, 10, 10, 100, 40, 40, 100, 0, 90, 100));
      send_item(make_item(25, 25, 100, 0, 90, 100, 10, 10, 100, 40, 40, 100));
      send_item(make_item(30, 30, 100, 40, 40, 100, 0, 90, 100, 10, 10, 100));
      // projection lands on camera origin
      send_item(make_item(0, 5, 0, -4, 0, 0, 4, 0, 0, 0, 0, 9));
      // degenerate edge with hit on another edge
      send_item(make_item(20, 20, 100, 10, 10, 100, 10, 10, 100, 30, 30, 100));
      // hit just off an edge and well away
      send_item(make_item(20, 21, 100, 10, 10, 100, 40, 40, 100, 0, 90, 100));
      send_item(make_item(-50, 3, -100, 10, 10, 100, 40, 40, 100, 0, 90, 100));
   endtask

   task automatic test_registers();
      write_reg(wet_pkg::CSR_LINE_RGB, 31'h7F12_3456);
      write_reg(wet_pkg::CSR_FILL_RGB, 31'h00AB_CDEF);
      write_reg(CSR_UNUSED, 31'h0000_0000);
      test_directed();
      write_reg(wet_pkg::CSR_COS_THRESHOLD, '0);
      test_directed();
      write_reg(wet_pkg::CSR_COS_THRESHOLD, wet_pkg::THR_ONE);
      test_directed();
      write_reg(wet_pkg::CSR_COS_THRESHOLD, wet_pkg::CSR_W'(wet_pkg::THR_ONE + 1'b1));
      test_directed();
      write_reg(wet_pkg::CSR_COS_THRESHOLD, '1);
      write_reg(wet_pkg::CSR_LINE_RGB, 31'h00FF_FFFF);
      write_reg(wet_pkg::CSR_FILL_RGB, '0);
      test_directed();
   endtask

   task automatic test_random(input int idle, input int stall, input int count,
                              input bit pause);
      int i;
      send_idle_pct = idle;
      recv_stall_pct = stall;
      case ($urandom_range(3))
         0: write_reg(wet_pkg::CSR_COS_THRESHOLD, wet_pkg::THR_RESET);
         1: write_reg(wet_pkg::CSR_COS_THRESHOLD,
                      wet_pkg::CSR_W'(wet_pkg::THR_ONE - $urandom_range(1 << 16)));
         2: write_reg(wet_pkg::CSR_COS_THRESHOLD,
                      wet_pkg::CSR_W'(wet_pkg::THR_ONE - $urandom_range(1 << 26)));
         default: write_reg(wet_pkg::CSR_COS_THRESHOLD, wet_pkg::CSR_W'($urandom));
      endcase
      write_reg(wet_pkg::CSR_LINE_RGB, wet_pkg::CSR_W'($urandom));
      write_reg(wet_pkg::CSR_FILL_RGB, wet_pkg::CSR_W'($urandom));
      for (i = 0; i < count; i++) begin
         if (pause && i == count / 2) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
            while (expected_shades.size() != 0) @(negedge clock);
         end
         send_item(random_item());
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_registers();
      test_random(0, 0, 220, 1'b0);
      test_random(81, 0, 220, 1'b1);
      test_random(0, 81, 220, 1'b0);
      test_random(30, 30, 220, 1'b0);
      drain();
      $display("sent %0d hits, %0d on an edge, across thresholds from zero to full scale",
               items_sent, edge_hits);
      $display("idle and stall mixes on both channels, %0d mismatches", mismatches);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
